// ===== src/gta_pkg.sv =====
// shared types, constants and lookup functions for the gimbal angle tracker
`default_nettype none
package gta_pkg;

	// fixed field widths
	localparam int BOX_W  = 12;
	localparam int CLS_W  = 8;
	localparam int GSD_W  = 16;
	localparam int DIST_W = 24;
	localparam int INT_W  = 16;
	localparam int CMD_W  = 15;

	// shared divider: 62-bit dividend, 32-bit divisor
	localparam int NUM_W = 62;
	localparam int DSR_W = 32;
	localparam int DCNT_W = 6;

	// cordic widths
	localparam int CX_W   = 34;
	localparam int CZ_W   = 27;
	localparam int ITERS  = 25;
	localparam int CI_W   = 5;

	// square root datapath width
	localparam int SQ_W = 62;

	// fixed point constants
	localparam logic [CX_W-1:0]  KINV_Q30   = CX_W'(652032874);
	localparam logic [NUM_W-1:0] ONE_Q30    = NUM_W'(64'd1 << 30);
	localparam logic [NUM_W-1:0] CLAMP_Q31  = NUM_W'(64'd1 << 31);
	localparam logic [SQ_W-1:0]  ONE_Q60    = SQ_W'(64'd1 << 60);
	localparam int               RECIP10    = 838861;
	localparam int               RECIP_SH   = 23;
	localparam int               RECIP_W    = 20;
	localparam int               ARG_SH     = 22;

	// command to Q24 angle: 2^24/10000 = 1677 + 451/625, the fraction by reciprocal of 625
	localparam int COSY_W    = 24;
	localparam int COS_RW    = 25;
	localparam int COS_HI    = 1677;
	localparam int COS_LO    = 451;
	localparam int COS_RND   = 312;
	localparam int COS_RECIP = 27487791;
	localparam int COS_SH    = 34;

	// opcode of an input beat
	localparam logic OPC_BOX  = 1'b0;
	localparam logic OPC_TICK = 1'b1;

	// register map
	typedef enum logic [2:0] {
		REG_TARGET_CLASS = 3'd0,
		REG_CENTER_X     = 3'd1,
		REG_CENTER_Y     = 3'd2,
		REG_GROUND       = 3'd3,
		REG_DISTANCE     = 3'd4,
		REG_MIN_INTERVAL = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CLS_W-1:0]  target_class;
		logic [BOX_W-1:0]  center_x;
		logic [BOX_W-1:0]  center_y;
		logic [GSD_W-1:0]  ground_sample;
		logic [DIST_W-1:0] target_distance;
		logic [INT_W-1:0]  min_interval;
	} cfg_t;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_ERR,
		S_MUL,
		S_DIVA_GO,
		S_DIVA_WAIT,
		S_ARG,
		S_DIVC_GO,
		S_DIVC_WAIT,
		S_ROT_GO,
		S_ROT_WAIT,
		S_PCHK,
		S_DIVP_WAIT,
		S_ARGP,
		S_SQ,
		S_SQRT_GO,
		S_SQRT_WAIT,
		S_VEC_GO,
		S_VEC_WAIT,
		S_CMD,
		S_EMIT
	} state_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_TICK,
		OP_SMOOTH,
		OP_ERR,
		OP_MUL,
		OP_DIV_ARG,
		OP_ARG,
		OP_DIV_COS,
		OP_CORD_ROT,
		OP_DIV_PITCH,
		OP_ARG_P,
		OP_ARG_PSAT,
		OP_SQ,
		OP_SQRT,
		OP_CORD_VEC,
		OP_CMD,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic pitch;
	} cmd_t;

	typedef struct packed {
		logic class_hit;
		logic busy;
		logic cos_pos;
		logic tick_ok;
		logic out_free;
	} sts_t;

	// arctangent of 2^-i in Q24 radians
	function automatic logic [CZ_W-1:0] atan_lut(input logic [CI_W-1:0] i);
		logic [CZ_W-1:0] v;
		case (i)
			5'd0:    v = CZ_W'(13176795);
			5'd1:    v = CZ_W'(7778716);
			5'd2:    v = CZ_W'(4110060);
			5'd3:    v = CZ_W'(2086331);
			5'd4:    v = CZ_W'(1047214);
			5'd5:    v = CZ_W'(524117);
			5'd6:    v = CZ_W'(262123);
			5'd7:    v = CZ_W'(131069);
			5'd8:    v = CZ_W'(65536);
			5'd9:    v = CZ_W'(32768);
			5'd10:   v = CZ_W'(16384);
			5'd11:   v = CZ_W'(8192);
			5'd12:   v = CZ_W'(4096);
			5'd13:   v = CZ_W'(2048);
			5'd14:   v = CZ_W'(1024);
			5'd15:   v = CZ_W'(512);
			5'd16:   v = CZ_W'(256);
			5'd17:   v = CZ_W'(128);
			5'd18:   v = CZ_W'(64);
			5'd19:   v = CZ_W'(32);
			5'd20:   v = CZ_W'(16);
			5'd21:   v = CZ_W'(8);
			5'd22:   v = CZ_W'(4);
			5'd23:   v = CZ_W'(2);
			5'd24:   v = CZ_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== src/gta_ctrl.sv =====
// sequencing state machine of the gimbal angle tracker
`default_nettype none
module gta_ctrl import gta_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic in_valid,
	input  wire  logic opcode,
	input  wire  sts_t sts,
	output logic       in_stall,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   phase_q;

	// state and phase registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE)
				phase_q <= 1'b0;
			else if (state_q == S_CMD)
				phase_q <= 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && opcode == OPC_BOX && sts.class_hit)
					state_d = S_ERR;
			end
			S_ERR:       state_d = S_MUL;
			S_MUL:       state_d = S_DIVA_GO;
			S_DIVA_GO:   state_d = S_DIVA_WAIT;
			S_DIVA_WAIT: if (!sts.busy) state_d = S_ARG;
			S_ARG:       state_d = phase_q ? S_DIVC_GO : S_SQ;
			S_DIVC_GO:   state_d = S_DIVC_WAIT;
			S_DIVC_WAIT: if (!sts.busy) state_d = S_ROT_GO;
			S_ROT_GO:    state_d = S_ROT_WAIT;
			S_ROT_WAIT:  if (!sts.busy) state_d = S_PCHK;
			S_PCHK:      state_d = sts.cos_pos ? S_DIVP_WAIT : S_SQ;
			S_DIVP_WAIT: if (!sts.busy) state_d = S_ARGP;
			S_ARGP:      state_d = S_SQ;
			S_SQ:        state_d = S_SQRT_GO;
			S_SQRT_GO:   state_d = S_SQRT_WAIT;
			S_SQRT_WAIT: if (!sts.busy) state_d = S_VEC_GO;
			S_VEC_GO:    state_d = S_VEC_WAIT;
			S_VEC_WAIT:  if (!sts.busy) state_d = S_CMD;
			S_CMD:       state_d = phase_q ? S_EMIT : S_MUL;
			S_EMIT: begin
				if (!sts.tick_ok || sts.out_free)
					state_d = S_IDLE;
			end
			default:     state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.op    = OP_NONE;
		cmd.pitch = phase_q;
		in_stall  = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (opcode == OPC_TICK)
						cmd.op = OP_TICK;
					else if (sts.class_hit)
						cmd.op = OP_SMOOTH;
				end
			end
			S_ERR:     cmd.op = OP_ERR;
			S_MUL:     cmd.op = OP_MUL;
			S_DIVA_GO: cmd.op = OP_DIV_ARG;
			S_ARG:     cmd.op = OP_ARG;
			S_DIVC_GO: cmd.op = OP_DIV_COS;
			S_ROT_GO:  cmd.op = OP_CORD_ROT;
			S_PCHK:    cmd.op = sts.cos_pos ? OP_DIV_PITCH : OP_ARG_PSAT;
			S_ARGP:    cmd.op = OP_ARG_P;
			S_SQ:      cmd.op = OP_SQ;
			S_SQRT_GO: cmd.op = OP_SQRT;
			S_VEC_GO:  cmd.op = OP_CORD_VEC;
			S_CMD:     cmd.op = OP_CMD;
			S_EMIT: begin
				if (sts.tick_ok && sts.out_free)
					cmd.op = OP_EMIT;
			end
			default:   cmd.op = OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/gta_dp.sv =====
// datapath: filter, shared divider, square root, cordic and output register
`default_nettype none
module gta_dp import gta_pkg::*; #(
	parameter int PIXEL_BITS = 12,
	parameter int TICK_BITS  = 16
) (
	input  wire  logic                    clk,
	input  wire  logic                    arst_n,
	input  wire  cfg_t                    cfg,
	input  wire  cmd_t                    cmd,
	input  wire  logic [CLS_W-1:0]        class_id,
	input  wire  logic [BOX_W-1:0]        box_left,
	input  wire  logic [BOX_W-1:0]        box_right,
	input  wire  logic [BOX_W-1:0]        box_top,
	input  wire  logic [BOX_W-1:0]        box_bottom,
	input  wire  logic                    out_stall,
	output sts_t                          sts,
	output logic                          out_valid,
	output logic signed [CMD_W-1:0]       yaw_cmd,
	output logic signed [CMD_W-1:0]       pitch_cmd,
	output logic                          out_of_range
);

	localparam int MW  = (PIXEL_BITS > BOX_W) ? PIXEL_BITS : BOX_W;
	localparam int VW  = MW + 4;
	localparam int PW  = VW + RECIP_W;
	localparam int GW  = MW + GSD_W;
	localparam int TW  = (TICK_BITS > INT_W) ? TICK_BITS : INT_W;
	localparam int ZW  = CZ_W + 1;
	localparam int MPW = ZW + CMD_W;
	localparam int CPW = COSY_W + COS_RW;

	// tracker state
	logic [PIXEL_BITS-1:0] fx_q, fy_q;
	logic [TICK_BITS-1:0]  ticks_q;

	// working registers
	logic [MW-1:0]          exm_q, eym_q;
	logic                   exn_q, eyn_q;
	logic [GW-1:0]          prod_q;
	logic [31:0]            a_q;
	logic [31:0]            bm_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   flag_q;
	logic signed [CMD_W-1:0] yaw_q, pitch_q;

	// divider registers
	logic [NUM_W-1:0]  dnum_q;
	logic [DSR_W-1:0]  drem_q, ddsr_q;
	logic [DCNT_W-1:0] dcnt_q;

	// square root registers
	logic [SQ_W-1:0] sv_q, sr_q, sb_q;

	// cordic registers
	logic signed [CX_W-1:0] cx_q, cy_q;
	logic signed [CZ_W-1:0] cz_q;
	logic [CI_W-1:0]        ci_q;
	logic                   crot_q, cbusy_q;

	// box centre and first-order filter, divide by ten by reciprocal
	logic [BOX_W:0]        sumx, sumy;
	logic [VW-1:0]         vx, vy;
	logic [PW-1:0]         px, py;
	logic [PIXEL_BITS-1:0] fx_new, fy_new;

	always_comb begin
		sumx   = {1'b0, box_left} + {1'b0, box_right};
		sumy   = {1'b0, box_top} + {1'b0, box_bottom};
		vx     = (VW'(fx_q) << 2) + (VW'(fx_q) << 1) + (VW'(sumx[BOX_W:1]) << 2);
		vy     = (VW'(fy_q) << 2) + (VW'(fy_q) << 1) + (VW'(sumy[BOX_W:1]) << 2);
		px     = PW'(vx) * PW'(RECIP10);
		py     = PW'(vy) * PW'(RECIP10);
		fx_new = px[RECIP_SH +: PIXEL_BITS];
		fy_new = py[RECIP_SH +: PIXEL_BITS];
	end

	// pixel errors
	logic signed [MW:0] exs, eys;
	always_comb begin
		exs = $signed({1'b0, MW'(fx_q)}) - $signed({1'b0, MW'(cfg.center_x)});
		eys = $signed({1'b0, MW'(cfg.center_y)}) - $signed({1'b0, MW'(fy_q)});
	end

	// quotient clamp helpers
	logic [NUM_W-1:0] quo;
	logic             q_over1;
	logic [31:0]      q_sat1, q_sat2;
	always_comb begin
		quo     = dnum_q;
		q_over1 = (quo > ONE_Q30);
		q_sat1  = q_over1 ? ONE_Q30[31:0] : quo[31:0];
		q_sat2  = (quo > CLAMP_Q31) ? CLAMP_Q31[31:0] : quo[31:0];
	end

	// angle to command, truncation toward zero
	logic                   cneg;
	logic signed [ZW-1:0]   zv;
	logic signed [MPW-1:0]  tp, tt;
	logic [MPW-1:0]         tmag, tsh;
	logic [CMD_W-1:0]       cmdv;
	always_comb begin
		cneg = cmd.pitch ? eyn_q : exn_q;
		zv   = cneg ? -ZW'(cz_q) : ZW'(cz_q);
		tp   = MPW'(zv) * $signed(MPW'(10000));
		tt   = tp + $signed(MPW'(1 << 23));
		tmag = tt[MPW-1] ? MPW'(-tt) : MPW'(tt);
		tsh  = tmag >> 24;
		cmdv = tt[MPW-1] ? CMD_W'(-tsh) : CMD_W'(tsh);
	end

	// cosine argument magnitude
	logic [CMD_W-1:0] ymag;
	assign ymag = yaw_q[CMD_W-1] ? CMD_W'(-yaw_q) : CMD_W'(yaw_q);

	// yaw command to rounded Q24 angle: fraction term registered first, then total
	logic [COSY_W-1:0] cos_y;
	logic [CPW-1:0]    cos_p;
	logic [CZ_W-1:0]   cos_z;
	always_comb begin
		cos_y = COSY_W'(ymag) * COSY_W'(COS_LO) + COSY_W'(COS_RND);
		cos_p = CPW'(dnum_q[COSY_W-1:0]) * CPW'(COS_RECIP);
		cos_z = CZ_W'(ymag) * CZ_W'(COS_HI) + CZ_W'(cos_p >> COS_SH);
	end

	// divider step
	logic [DSR_W:0] dsh;
	logic           dge;
	always_comb begin
		dsh = {drem_q, dnum_q[NUM_W-1]};
		dge = (dsh >= {1'b0, ddsr_q});
	end

	// square root step
	logic [SQ_W-1:0] st;
	assign st = sr_q + sb_q;

	// cordic step
	logic signed [CX_W-1:0] xs, ys;
	logic signed [CZ_W-1:0] at;
	logic                   cdir;
	always_comb begin
		xs   = cx_q >>> ci_q;
		ys   = cy_q >>> ci_q;
		at   = $signed(atan_lut(ci_q));
		cdir = crot_q ? cz_q[CZ_W-1] : !cy_q[CX_W-1];
	end

	// status
	always_comb begin
		sts.class_hit = (class_id == cfg.target_class);
		sts.busy      = (dcnt_q != '0) || (sb_q != '0) || cbusy_q;
		sts.cos_pos   = !cx_q[CX_W-1] && (cx_q != '0);
		sts.tick_ok   = (TW'(ticks_q) >= TW'(cfg.min_interval));
		sts.out_free  = !out_valid || !out_stall;
	end

	// control state: filter, tick count, unit counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q      <= '0;
			fy_q      <= '0;
			ticks_q   <= '1;
			dcnt_q    <= '0;
			sb_q      <= '0;
			cbusy_q   <= 1'b0;
			ci_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.op == OP_SMOOTH) begin
				fx_q <= fx_new;
				fy_q <= fy_new;
			end
			if (cmd.op == OP_TICK && ticks_q != '1)
				ticks_q <= ticks_q + 1'b1;
			else if (cmd.op == OP_EMIT)
				ticks_q <= '0;

			// divider count
			if (cmd.op == OP_DIV_ARG || cmd.op == OP_DIV_PITCH)
				dcnt_q <= DCNT_W'(NUM_W);
			else if (dcnt_q != '0)
				dcnt_q <= dcnt_q - 1'b1;

			// root bit walks down two places a step
			if (cmd.op == OP_SQRT)
				sb_q <= ONE_Q60;
			else if (sb_q != '0)
				sb_q <= sb_q >> 2;

			// cordic iteration count
			if (cmd.op == OP_CORD_ROT || cmd.op == OP_CORD_VEC) begin
				cbusy_q <= 1'b1;
				ci_q    <= '0;
			end else if (cbusy_q) begin
				if (ci_q == CI_W'(ITERS - 1))
					cbusy_q <= 1'b0;
				ci_q <= ci_q + 1'b1;
			end

			// output beat handshake
			if (cmd.op == OP_EMIT)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		// errors
		if (cmd.op == OP_ERR) begin
			exn_q <= exs[MW];
			eyn_q <= eys[MW];
			exm_q <= exs[MW] ? MW'(-exs) : MW'(exs);
			eym_q <= eys[MW] ? MW'(-eys) : MW'(eys);
		end
		if (cmd.op == OP_SMOOTH)
			flag_q <= 1'b0;

		// error times ground sample
		if (cmd.op == OP_MUL)
			prod_q <= GW'(cmd.pitch ? eym_q : exm_q) * GW'(cfg.ground_sample);

		// argument capture and saturation
		if (cmd.op == OP_ARG) begin
			if (cmd.pitch) begin
				bm_q <= q_sat2;
			end else begin
				a_q <= q_sat1;
				if (q_over1)
					flag_q <= 1'b1;
			end
		end
		if (cmd.op == OP_ARG_P) begin
			a_q <= q_sat1;
			if (q_over1)
				flag_q <= 1'b1;
		end
		if (cmd.op == OP_ARG_PSAT) begin
			if (bm_q != '0) begin
				a_q    <= ONE_Q30[31:0];
				flag_q <= 1'b1;
			end else begin
				a_q <= '0;
			end
		end

		// square of the argument
		if (cmd.op == OP_SQ)
			sq_q <= SQ_W'(a_q) * SQ_W'(a_q);

		// divider load and step
		case (cmd.op)
			OP_DIV_ARG: begin
				dnum_q <= NUM_W'({prod_q, ARG_SH'(0)});
				drem_q <= '0;
				ddsr_q <= (cfg.target_distance == '0) ? DSR_W'(1) : DSR_W'(cfg.target_distance);
			end
			OP_DIV_COS: begin
				dnum_q <= NUM_W'(cos_y);
			end
			OP_DIV_PITCH: begin
				dnum_q <= NUM_W'({bm_q, 30'd0});
				drem_q <= '0;
				ddsr_q <= cx_q[DSR_W-1:0];
			end
			default: begin
				if (dcnt_q != '0) begin
					drem_q <= dge ? DSR_W'(dsh - {1'b0, ddsr_q}) : dsh[DSR_W-1:0];
					dnum_q <= {dnum_q[NUM_W-2:0], dge};
				end
			end
		endcase

		// square root load and step
		if (cmd.op == OP_SQRT) begin
			sv_q <= ONE_Q60 - sq_q;
			sr_q <= '0;
		end else if (sb_q != '0) begin
			if (sv_q >= st) begin
				sv_q <= sv_q - st;
				sr_q <= (sr_q >> 1) + sb_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
		end

		// cordic load and step
		case (cmd.op)
			OP_CORD_ROT: begin
				crot_q <= 1'b1;
				cx_q   <= $signed(KINV_Q30);
				cy_q   <= '0;
				cz_q   <= $signed(cos_z);
			end
			OP_CORD_VEC: begin
				crot_q <= 1'b0;
				cx_q   <= $signed(CX_W'(sr_q));
				cy_q   <= $signed(CX_W'(a_q));
				cz_q   <= '0;
			end
			default: begin
				if (cbusy_q) begin
					if (cdir) begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + at;
					end else begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - at;
					end
				end
			end
		endcase

		// rounded angle commands
		if (cmd.op == OP_CMD) begin
			if (cmd.pitch)
				pitch_q <= $signed(cmdv);
			else
				yaw_q <= $signed(cmdv);
		end

		// output beat payload
		if (cmd.op == OP_EMIT) begin
			yaw_cmd      <= yaw_q;
			pitch_cmd    <= pitch_q;
			out_of_range <= flag_q;
		end
	end

endmodule
`default_nettype wire

// ===== src/bbox_track_gimbal_angles.sv =====
// top level: configuration registers, controller and datapath
//
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   opcode, class_id, box_left/right/top/bottom
// out       output     out_valid/out_stall yaw_cmd, pitch_cmd, out_of_range
// apb       input      psel/penable        paddr, pwdata, prdata
//
// A tick or a box of another class is taken in the idle state without a stall. A
// tracked box stalls the input through three passes of the shared 62-step restoring
// divider, two 31-step square roots and three 25-step cordic runs, one after the
// other; a non-positive cosine skips the pitch division.
// Reset clears the filter, saturates the tick count and loads register defaults.
// The result sits in an output register, so out_stall can only hold a box at
// its final step, never earlier.
`default_nettype none
module bbox_track_gimbal_angles import gta_pkg::*; #(
	parameter int PIXEL_BITS = 12,
	parameter int TICK_BITS  = 16
) (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	input  wire  logic                  psel,
	input  wire  logic                  penable,
	input  wire  logic                  pwrite,
	input  wire  logic [4:0]            paddr,
	input  wire  logic [31:0]           pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  wire  logic                  in_valid,
	output logic                        in_stall,
	input  wire  logic                  opcode,
	input  wire  logic [CLS_W-1:0]      class_id,
	input  wire  logic [BOX_W-1:0]      box_left,
	input  wire  logic [BOX_W-1:0]      box_right,
	input  wire  logic [BOX_W-1:0]      box_top,
	input  wire  logic [BOX_W-1:0]      box_bottom,
	output logic                        out_valid,
	input  wire  logic                  out_stall,
	output logic signed [CMD_W-1:0]     yaw_cmd,
	output logic signed [CMD_W-1:0]     pitch_cmd,
	output logic                        out_of_range
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_class    <= CLS_W'(56);
			cfg_q.center_x        <= BOX_W'(640);
			cfg_q.center_y        <= BOX_W'(360);
			cfg_q.ground_sample   <= GSD_W'(3490);
			cfg_q.target_distance <= DIST_W'(65536);
			cfg_q.min_interval    <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_TARGET_CLASS: cfg_q.target_class    <= pwdata[CLS_W-1:0];
				REG_CENTER_X:     cfg_q.center_x        <= pwdata[BOX_W-1:0];
				REG_CENTER_Y:     cfg_q.center_y        <= pwdata[BOX_W-1:0];
				REG_GROUND:       cfg_q.ground_sample   <= pwdata[GSD_W-1:0];
				REG_DISTANCE:     cfg_q.target_distance <= pwdata[DIST_W-1:0];
				REG_MIN_INTERVAL: cfg_q.min_interval    <= pwdata[INT_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (ridx)
			REG_TARGET_CLASS: prdata = 32'(cfg_q.target_class);
			REG_CENTER_X:     prdata = 32'(cfg_q.center_x);
			REG_CENTER_Y:     prdata = 32'(cfg_q.center_y);
			REG_GROUND:       prdata = 32'(cfg_q.ground_sample);
			REG_DISTANCE:     prdata = 32'(cfg_q.target_distance);
			REG_MIN_INTERVAL: prdata = 32'(cfg_q.min_interval);
			default:          prdata = '0;
		endcase
	end

	gta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	gta_dp #(
		.PIXEL_BITS (PIXEL_BITS),
		.TICK_BITS  (TICK_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.class_id     (class_id),
		.box_left     (box_left),
		.box_right    (box_right),
		.box_top      (box_top),
		.box_bottom   (box_bottom),
		.out_stall    (out_stall),
		.sts          (sts),
		.out_valid    (out_valid),
		.yaw_cmd      (yaw_cmd),
		.pitch_cmd    (pitch_cmd),
		.out_of_range (out_of_range)
	);

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the gimbal angle tracker: directed, extreme and random traffic against a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import gta_pkg::*;

	localparam int LIMIT = 4000000;
	localparam int DRAIN = 500;
	localparam longint ATAN_Q24 [25] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1
	};

	typedef struct {
		logic [CMD_W-1:0] yaw;
		logic [CMD_W-1:0] pitch;
		logic             flag;
	} angle_cmd_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall, opcode;
	logic [CLS_W-1:0] class_id;
	logic [BOX_W-1:0] box_left, box_right, box_top, box_bottom;
	logic out_valid, out_stall, out_of_range;
	logic signed [CMD_W-1:0] yaw_cmd, pitch_cmd;

	// shadow of registers and tracker state
	cfg_t shadow_cfg;
	logic [BOX_W-1:0] filt_x, filt_y;
	logic [15:0] tick_count;

	angle_cmd_t angle_q[$];
	int errors;
	int cycles;
	int send_idle, recv_idle;
	int hold_left;

	bbox_track_gimbal_angles dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// cycle count and run limit
	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= LIMIT);
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// vectoring cordic: asin of a Q30 magnitude, Q24 radians
	function automatic longint asin_q24(logic [63:0] a);
		longint x, y, z, nx, ny;
		x = longint'(isqrt64((64'd1 << 60) - a * a));
		y = longint'(a);
		z = 0;
		for (int i = 0; i < 25; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_Q24[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_Q24[i];
			end
			x = nx; y = ny;
		end
		return z;
	endfunction

	// rotation cordic: Q30 cosine of an angle in 1e-4 rad
	function automatic longint cos_q30(longint n);
		longint m, x, y, z, nx, ny;
		m = (n < 0) ? -n : n;
		z = ((m << 24) + 5000) / 10000;
		x = 652032874;
		y = 0;
		for (int i = 0; i < 25; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_Q24[i];
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_Q24[i];
			end
			x = nx; y = ny;
		end
		return x;
	endfunction

	function automatic longint angle_to_cmd(bit neg, longint zmag);
		longint t;
		t = (neg ? -zmag : zmag) * 10000 + (longint'(1) << 23);
		return (t >= 0) ? (t >>> 24) : -((-t) >>> 24);
	endfunction

	function automatic logic [63:0] scaled_arg(logic [63:0] emag);
		logic [63:0] d, q;
		d = (shadow_cfg.target_distance == 0) ? 64'd1 : 64'(shadow_cfg.target_distance);
		q = ((emag * 64'(shadow_cfg.ground_sample)) << 22) / d;
		return (q > (64'd1 << 31)) ? (64'd1 << 31) : q;
	endfunction

	// predict the command caused by one accepted beat
	function automatic void predict_angles(logic op, logic [7:0] cls, logic [11:0] l,
			logic [11:0] r, logic [11:0] t, logic [11:0] b);
		longint ex, ey, yaw, pitch, c;
		logic [63:0] am, bm;
		bit flag;
		angle_cmd_t e;
		flag = 0;
		if (op == OPC_TICK) begin
			if (tick_count != 16'hffff) tick_count = tick_count + 1;
			return;
		end
		if (cls != shadow_cfg.target_class) return;
		filt_x = BOX_W'((6 * 64'(filt_x) + 4 * ((64'(l) + 64'(r)) >> 1)) / 10);
		filt_y = BOX_W'((6 * 64'(filt_y) + 4 * ((64'(t) + 64'(b)) >> 1)) / 10);
		ex = longint'(filt_x) - longint'(shadow_cfg.center_x);
		ey = longint'(shadow_cfg.center_y) - longint'(filt_y);
		am = scaled_arg(64'(ex < 0 ? -ex : ex));
		if (am > (64'd1 << 30)) begin
			am = 64'd1 << 30; flag = 1;
		end
		yaw = angle_to_cmd(ex < 0, asin_q24(am));
		bm = scaled_arg(64'(ey < 0 ? -ey : ey));
		c = cos_q30(yaw);
		// non-positive cosine saturates unless the pitch argument is zero
		if (c <= 0) begin
			if (bm != 0) begin
				bm = 64'd1 << 30; flag = 1;
			end
		end else begin
			bm = (bm << 30) / 64'(c);
			if (bm > (64'd1 << 30)) begin
				bm = 64'd1 << 30; flag = 1;
			end
		end
		pitch = angle_to_cmd(ey < 0, asin_q24(bm));
		if (tick_count < shadow_cfg.min_interval) return;
		tick_count = 0;
		e.yaw = CMD_W'(yaw);
		e.pitch = CMD_W'(pitch);
		e.flag = flag;
		angle_q.push_back(e);
	endfunction

	// receiver stall: long hold-off when asked, else random
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// compare each result beat with the oldest expected command
	always @(posedge clk) begin
		angle_cmd_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (angle_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result yaw %0d pitch %0d", yaw_cmd, pitch_cmd);
			end else begin
				e = angle_q.pop_front();
				if (yaw_cmd !== e.yaw || pitch_cmd !== e.pitch || out_of_range !== e.flag) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp yaw %0d pitch %0d flag %0b, got %0d %0d %0b",
							$signed(e.yaw), $signed(e.pitch), e.flag,
							yaw_cmd, pitch_cmd, out_of_range);
				end
			end
		end
	end

	// send one beat, with an optional random gap ahead of it
	task automatic send_beat(logic op, logic [7:0] cls, logic [11:0] l, logic [11:0] r,
			logic [11:0] t, logic [11:0] b);
		int gap;
		gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		class_id <= cls;
		box_left <= l;
		box_right <= r;
		box_top <= t;
		box_bottom <= b;
		do @(posedge clk); while (in_stall);
		predict_angles(op, cls, l, r, t, b);
	endtask

	task automatic send_box(logic [7:0] cls, logic [11:0] l, logic [11:0] r,
			logic [11:0] t, logic [11:0] b);
		send_beat(OPC_BOX, cls, l, r, t, b);
	endtask

	task automatic send_tick();
		send_beat(OPC_TICK, 8'($urandom), 12'($urandom), 12'($urandom),
			12'($urandom), 12'($urandom));
	endtask

	// stop sending and let every pending command come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (angle_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	// register write, setup then access; high bits beyond the field are junk
	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * int'(idx));
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TARGET_CLASS: shadow_cfg.target_class = val[CLS_W-1:0];
			REG_CENTER_X:     shadow_cfg.center_x = val[BOX_W-1:0];
			REG_CENTER_Y:     shadow_cfg.center_y = val[BOX_W-1:0];
			REG_GROUND:       shadow_cfg.ground_sample = val[GSD_W-1:0];
			REG_DISTANCE:     shadow_cfg.target_distance = val[DIST_W-1:0];
			REG_MIN_INTERVAL: shadow_cfg.min_interval = val[INT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic rand_box(logic [7:0] cls);
		send_box(cls, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
	endtask

	// random box with its centre near the set point so that angles stay in range
	task automatic near_box(int spread);
		int cx, cy, dx, dy;
		cx = int'(shadow_cfg.center_x) + $urandom_range(0, 2 * spread) - spread;
		cy = int'(shadow_cfg.center_y) + $urandom_range(0, 2 * spread) - spread;
		dx = $urandom_range(0, 200);
		dy = $urandom_range(0, 200);
		send_box(shadow_cfg.target_class, 12'(cx - dx), 12'(cx + dx), 12'(cy - dy), 12'(cy + dy));
	endtask

	// defaults, field extremes, other class, reversed edges, suppression
	task automatic test_directed();
		send_box(8'd56, 12'd0, 12'd0, 12'd0, 12'd0);
		send_box(8'd56, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
		send_box(8'd56, 12'hfff, 12'd0, 12'hfff, 12'd0);
		send_box(8'd55, 12'd100, 12'd200, 12'd100, 12'd200);
		send_box(8'hff, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
		send_box(8'd56, 12'd600, 12'd680, 12'd320, 12'd400);
		send_tick();
		send_box(8'd56, 12'd640, 12'd640, 12'd360, 12'd360);
		drain();
		// a minimum interval of three ticks suppresses every command until three ticks have passed
		reg_write(REG_MIN_INTERVAL, 32'h0000_0003);
		send_box(8'd56, 12'd900, 12'd1000, 12'd100, 12'd200);
		send_box(8'd56, 12'd900, 12'd1000, 12'd100, 12'd200);
		send_tick();
		send_tick();
		send_box(8'd56, 12'd10, 12'd20, 12'd700, 12'd710);
		send_tick();
		send_box(8'd56, 12'd10, 12'd20, 12'd700, 12'd710);
		drain();
		reg_write(REG_MIN_INTERVAL, 32'hffff_0000);
	endtask

	// saturation: huge scale, zero distance, corners of the set point
	task automatic test_limits();
		reg_write(REG_TARGET_CLASS, 32'h0000_0000);
		reg_write(REG_GROUND, 32'h0000_ffff);
		reg_write(REG_DISTANCE, 32'h0000_0000);
		reg_write(REG_CENTER_X, 32'h0000_0fff);
		reg_write(REG_CENTER_Y, 32'h0000_0000);
		send_box(8'd0, 12'd0, 12'd0, 12'd0, 12'd0);
		send_box(8'd0, 12'hfff, 12'hfff, 12'd0, 12'd0);
		send_box(8'd0, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
		drain();
		reg_write(REG_TARGET_CLASS, 32'h0000_00ff);
		reg_write(REG_DISTANCE, 32'h00ff_ffff);
		reg_write(REG_CENTER_X, 32'h0000_0000);
		reg_write(REG_CENTER_Y, 32'h0000_0fff);
		send_box(8'hff, 12'hfff, 12'hfff, 12'd0, 12'd0);
		send_box(8'hff, 12'd0, 12'd0, 12'hfff, 12'hfff);
		drain();
		reg_write(REG_GROUND, 32'h0000_0000);
		send_box(8'hff, 12'hfff, 12'd0, 12'd5, 12'd9);
		drain();
	endtask

	// random config and traffic: mostly tracked boxes, some ticks and other classes
	task automatic test_random(int beats);
		int kind;
		drain();
		reg_write(REG_TARGET_CLASS, $urandom);
		reg_write(REG_CENTER_X, $urandom_range(0, 4095));
		reg_write(REG_CENTER_Y, $urandom_range(0, 4095));
		reg_write(REG_GROUND, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(500, 8000));
		reg_write(REG_DISTANCE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(20000, 400000));
		reg_write(REG_MIN_INTERVAL, $urandom_range(0, 2));
		for (int n = 0; n < beats; n++) begin
			kind = $urandom_range(99);
			if (kind < 45) near_box($urandom_range(0, 2) == 0 ? 2000 : 300);
			else if (kind < 65) rand_box(shadow_cfg.target_class);
			else if (kind < 88) send_tick();
			else rand_box(8'($urandom));
		end
		drain();
	endtask

	// long receiver hold while boxes keep coming, then a full pause
	task automatic test_backpressure();
		reg_write(REG_MIN_INTERVAL, 32'h0000_0000);
		hold_left = 1500;
		for (int n = 0; n < 8; n++) near_box(200);
		drain();
	endtask

	initial begin
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; opcode = 0; class_id = '0;
		box_left = '0; box_right = '0; box_top = '0; box_bottom = '0;
		out_stall = 0;
		errors = 0; cycles = 0; hold_left = 0;
		send_idle = 37; recv_idle = 49;
		shadow_cfg = '{target_class: 8'd56, center_x: 12'd640, center_y: 12'd360,
			ground_sample: 16'd3490, target_distance: 24'd65536, min_interval: 16'd0};
		filt_x = '0; filt_y = '0; tick_count = 16'hffff;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_directed();
		test_limits();
		test_random(160);
		test_random(160);
		send_idle = 49; recv_idle = 37;
		test_backpressure();
		test_random(160);
		test_random(160);
		send_idle = 0; recv_idle = 0;
		test_random(160);
		test_random(160);

		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
